// ----- sv/xs1024_pkg.sv -----
// Shared types and constants for the xorshift1024* generator.
`default_nettype none

package xs1024_pkg;

   localparam int WordW      = 64;
   localparam int IdxW       = 4;
   localparam int StateWords = 16;
   localparam int ReqDataW   = 72;
   localparam int RspDataW   = 136;
   localparam int FuncW      = 2;

   localparam logic [WordW-1:0] Multiplier = 64'd1181783497276652981;

   localparam int ShiftA = 31;
   localparam int ShiftB = 11;
   localparam int ShiftC = 30;

   typedef enum logic [FuncW-1:0] {
      FuncGenerate = 2'd0,
      FuncWrite    = 2'd1,
      FuncSetPos   = 2'd2
   } func_type;

   // one write into the state store
   typedef struct packed {
      logic            en;
      logic [IdxW-1:0] addr;
      logic [WordW-1:0] data;
   } mem_wr_type;

   // paired read of the state store
   typedef struct packed {
      logic            en;
      logic [IdxW-1:0] addr_a;
      logic [IdxW-1:0] addr_b;
   } mem_rd_type;

endpackage

`default_nettype wire

// ----- sv/xs1024_mem.sv -----
// State word store: 16 x 64, two registered reads, one write, valid bits per entry.
`default_nettype none

module xs1024_mem (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire xs1024_pkg::mem_rd_type      rd,
   input  wire xs1024_pkg::mem_wr_type      wr,
   output logic [xs1024_pkg::WordW-1:0]     rd_data_a,
   output logic [xs1024_pkg::WordW-1:0]     rd_data_b
);

   logic [xs1024_pkg::WordW-1:0]      store_mem [xs1024_pkg::StateWords];
   logic [xs1024_pkg::WordW-1:0]      rd_a_ff;
   logic [xs1024_pkg::WordW-1:0]      rd_b_ff;
   logic [xs1024_pkg::StateWords-1:0] vld_ff;
   logic                              va_ff;
   logic                              vb_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         store_mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_a_ff <= store_mem[rd.addr_a];
         rd_b_ff <= store_mem[rd.addr_b];
      end
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         va_ff  <= 1'b0;
         vb_ff  <= 1'b0;
      end else begin
         if (wr.en) begin
            vld_ff[wr.addr] <= 1'b1;
         end
         if (rd.en) begin
            va_ff <= vld_ff[rd.addr_a];
            vb_ff <= vld_ff[rd.addr_b];
         end
      end
   end

   assign rd_data_a = va_ff ? rd_a_ff : '0;
   assign rd_data_b = vb_ff ? rd_b_ff : '0;

   a_wr_marks_valid: assert property (@(posedge clock) disable iff (reset)
      wr.en |=> vld_ff[$past(wr.addr)])
      else $error("written entry not marked valid");

endmodule

`default_nettype wire

// ----- sv/xs1024_mult.sv -----
// Two-stage 64 x 64 low-half multiply by the fixed xorshift1024* constant.
`default_nettype none

module xs1024_mult (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   output logic                             in_ready,
   input  wire logic [xs1024_pkg::WordW-1:0] in_word,
   input  wire logic [xs1024_pkg::IdxW-1:0]  in_pos,
   output logic                             out_valid,
   input  wire logic                        out_ready,
   output logic [xs1024_pkg::WordW-1:0]     out_word,
   output logic [xs1024_pkg::IdxW-1:0]      out_pos
);

   localparam int HalfW = xs1024_pkg::WordW / 2;
   localparam logic [HalfW-1:0] MulLo = xs1024_pkg::Multiplier[HalfW-1:0];
   localparam logic [HalfW-1:0] MulHi = xs1024_pkg::Multiplier[xs1024_pkg::WordW-1:HalfW];

   logic [HalfW-1:0]              a_lo;
   logic [HalfW-1:0]              a_hi;
   logic [xs1024_pkg::WordW-1:0]  pp0_in;
   logic [HalfW-1:0]              pp1_in;
   logic [HalfW-1:0]              pp2_in;
   logic [xs1024_pkg::WordW-1:0]  pp0_ff;
   logic [HalfW-1:0]              pp1_ff;
   logic [HalfW-1:0]              pp2_ff;
   logic [xs1024_pkg::IdxW-1:0]   pp_pos_ff;
   logic                          pp_v_ff;
   logic [xs1024_pkg::WordW-1:0]  word_in;
   logic [HalfW-1:0]              cross_sum;
   logic [xs1024_pkg::WordW-1:0]  out_word_ff;
   logic [xs1024_pkg::IdxW-1:0]   out_pos_ff;
   logic                          out_v_ff;
   logic                          o_ready;
   logic                          pp_ready;
   logic                          in_fire;
   logic                          pp_move;

   assign a_lo = in_word[HalfW-1:0];
   assign a_hi = in_word[xs1024_pkg::WordW-1:HalfW];

   // cross terms only matter in their low half
   assign pp0_in = xs1024_pkg::WordW'(a_lo) * xs1024_pkg::WordW'(MulLo);
   assign pp1_in = HalfW'(a_hi * MulLo);
   assign pp2_in = HalfW'(a_lo * MulHi);

   assign cross_sum = HalfW'(pp1_ff + pp2_ff);
   assign word_in   = pp0_ff + {cross_sum, {HalfW{1'b0}}};

   assign o_ready  = !out_v_ff || out_ready;
   assign pp_ready = !pp_v_ff || o_ready;
   assign in_ready = pp_ready;
   assign in_fire  = in_valid && pp_ready;
   assign pp_move  = pp_v_ff && o_ready;

   always_ff @(posedge clock) begin
      if (in_fire) begin
         pp0_ff    <= pp0_in;
         pp1_ff    <= pp1_in;
         pp2_ff    <= pp2_in;
         pp_pos_ff <= in_pos;
      end
      if (pp_move) begin
         out_word_ff <= word_in;
         out_pos_ff  <= pp_pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pp_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (pp_ready) begin
            pp_v_ff <= in_valid;
         end
         if (o_ready) begin
            out_v_ff <= pp_v_ff;
         end
      end
   end

   assign out_valid = out_v_ff;
   assign out_word  = out_word_ff;
   assign out_pos   = out_pos_ff;

   a_pp_holds: assert property (@(posedge clock) disable iff (reset)
      pp_v_ff && !o_ready |=> pp_v_ff && $stable(pp0_ff))
      else $error("partial products dropped under stall");

   a_in_reaches_pp: assert property (@(posedge clock) disable iff (reset)
      in_fire |=> pp_v_ff && pp_pos_ff == $past(in_pos))
      else $error("accepted word lost before partial stage");

endmodule

`default_nettype wire

// ----- sv/xorshift1024star_generator_unit.sv -----
// Top level of the xorshift1024* generator: pointer, state update, forwarding, output.
//
//   channel | dir | beat content
//   req_    | in  | tuser: func; tdata: word_index, seed_word
//   rsp_    | out | tdata: random_word, unit_fraction, position
//
// One beat per cycle sustained while rsp_tready is high; a result passes the update
//   stage, the partial-product register and the output register before it is offered.
// Each request issues both state reads at accept; the new word is written back when
//   the update stage leaves and is forwarded to a read issued in that same cycle.
// Reset clears the pointer, the per-entry valid bits and all pipeline valids; no sweep.
// With rsp_tready low the output, product and update stages fill before req_tready drops.
// Write and set-position beats produce no result; func code 3 is accepted and dropped.
`default_nettype none

module xorshift1024star_generator_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // [3:0] word_index, [67:4] seed_word, [71:68] zero
   input  wire logic [xs1024_pkg::ReqDataW-1:0]    req_tdata,
   // [1:0] func
   input  wire logic [xs1024_pkg::FuncW-1:0]       req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [63:0] random_word, [127:64] unit_fraction, [131:128] position, [135:132] zero
   output logic [xs1024_pkg::RspDataW-1:0]         rsp_tdata
);

   localparam int WordW = xs1024_pkg::WordW;
   localparam int IdxW  = xs1024_pkg::IdxW;
   localparam int PadW  = xs1024_pkg::RspDataW - 2 * WordW - IdxW;

   xs1024_pkg::func_type   req_func;
   logic [IdxW-1:0]        req_idx;
   logic [WordW-1:0]       req_seed;
   logic                   req_fire;

   logic [IdxW-1:0]        ptr_ff;
   logic [IdxW-1:0]        ptr_in;
   logic [IdxW-1:0]        ptr_next;

   logic                   s1_v_ff;
   logic                   s1_v_in;
   logic                   s1_gen_ff;
   logic                   s1_gen_in;
   logic [IdxW-1:0]        s1_addr_a_ff;
   logic [IdxW-1:0]        s1_addr_b_ff;
   logic [IdxW-1:0]        s1_waddr_ff;
   logic [WordW-1:0]       s1_seed_ff;
   logic                   s1_leave;
   logic                   s1_ready;

   logic                   fwd_v_ff;
   logic [IdxW-1:0]        fwd_addr_ff;
   logic [WordW-1:0]       fwd_data_ff;

   logic [WordW-1:0]       mem_a;
   logic [WordW-1:0]       mem_b;
   logic [WordW-1:0]       word_a;
   logic [WordW-1:0]       word_b;
   logic [WordW-1:0]       b_sh1;
   logic [WordW-1:0]       b_sh2;
   logic [WordW-1:0]       a_sh;
   logic [WordW-1:0]       new_word;

   xs1024_pkg::mem_rd_type rd_req;
   xs1024_pkg::mem_wr_type wr_req;

   logic                   mul_in_ready;
   logic [WordW-1:0]       rand_word;
   logic [IdxW-1:0]        rand_pos;

   assign req_func = xs1024_pkg::func_type'(req_tuser);
   assign req_idx  = req_tdata[IdxW-1:0];
   assign req_seed = req_tdata[IdxW+WordW-1:IdxW];

   assign ptr_next = IdxW'(ptr_ff + 1'b1);

   // the update stage frees itself unless a generated word waits on the multiplier
   assign s1_leave   = s1_v_ff && (!s1_gen_ff || mul_in_ready);
   assign s1_ready   = !s1_v_ff || s1_leave;
   assign req_tready = s1_ready;
   assign req_fire   = req_tvalid && s1_ready;

   always_comb begin
      ptr_in    = ptr_ff;
      s1_v_in   = s1_v_ff && !s1_leave;
      s1_gen_in = s1_gen_ff;
      if (req_fire) begin
         s1_v_in   = 1'b0;
         s1_gen_in = 1'b0;
         unique case (req_func)
            xs1024_pkg::FuncGenerate: begin
               ptr_in    = ptr_next;
               s1_v_in   = 1'b1;
               s1_gen_in = 1'b1;
            end
            xs1024_pkg::FuncWrite: begin
               s1_v_in = 1'b1;
            end
            xs1024_pkg::FuncSetPos: begin
               ptr_in = req_idx;
            end
            default: begin
               ptr_in = ptr_ff;
            end
         endcase
      end
   end

   assign rd_req.en     = req_fire;
   assign rd_req.addr_a = ptr_ff;
   assign rd_req.addr_b = ptr_next;

   xs1024_mem u_mem (
      .clock     (clock),
      .reset     (reset),
      .rd        (rd_req),
      .wr        (wr_req),
      .rd_data_a (mem_a),
      .rd_data_b (mem_b)
   );

   // the write landing on the read edge is not in the read data
   assign word_a = (fwd_v_ff && fwd_addr_ff == s1_addr_a_ff) ? fwd_data_ff : mem_a;
   assign word_b = (fwd_v_ff && fwd_addr_ff == s1_addr_b_ff) ? fwd_data_ff : mem_b;

   assign b_sh1    = word_b ^ (word_b << xs1024_pkg::ShiftA);
   assign b_sh2    = b_sh1 ^ (b_sh1 >> xs1024_pkg::ShiftB);
   assign a_sh     = word_a ^ (word_a >> xs1024_pkg::ShiftC);
   assign new_word = a_sh ^ b_sh2;

   assign wr_req.en   = s1_leave;
   assign wr_req.addr = s1_waddr_ff;
   assign wr_req.data = s1_gen_ff ? new_word : s1_seed_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_addr_a_ff <= ptr_ff;
         s1_addr_b_ff <= ptr_next;
         s1_waddr_ff  <= (req_func == xs1024_pkg::FuncGenerate) ? ptr_next : req_idx;
         s1_seed_ff   <= req_seed;
      end
      if (s1_leave) begin
         fwd_addr_ff <= wr_req.addr;
         fwd_data_ff <= wr_req.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff    <= '0;
         s1_v_ff   <= 1'b0;
         s1_gen_ff <= 1'b0;
         fwd_v_ff  <= 1'b0;
      end else begin
         ptr_ff    <= ptr_in;
         s1_v_ff   <= s1_v_in;
         s1_gen_ff <= s1_gen_in;
         if (s1_leave) begin
            fwd_v_ff <= 1'b1;
         end
      end
   end

   xs1024_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_v_ff && s1_gen_ff),
      .in_ready  (mul_in_ready),
      .in_word   (new_word),
      .in_pos    (s1_addr_b_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (rand_word),
      .out_pos   (rand_pos)
   );

   assign rsp_tdata = {{PadW{1'b0}}, rand_pos, ~rand_word[WordW-1], rand_word[WordW-2:0],
                       rand_word};

   a_gen_enters_update: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_func == xs1024_pkg::FuncGenerate |=> s1_v_ff && s1_gen_ff)
      else $error("generate beat did not reach update stage");

   a_gen_advances_ptr: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_func == xs1024_pkg::FuncGenerate
      |=> ptr_ff == IdxW'($past(ptr_ff) + 1'b1))
      else $error("pointer did not advance on generate");

   a_write_at_new_pos: assert property (@(posedge clock) disable iff (reset)
      s1_leave && s1_gen_ff |-> wr_req.addr == s1_addr_b_ff)
      else $error("generated word written at wrong entry");

   a_fwd_tracks_write: assert property (@(posedge clock) disable iff (reset)
      s1_leave |=> fwd_v_ff && fwd_addr_ff == $past(s1_waddr_ff))
      else $error("forward register missed a write");

endmodule

`default_nettype wire
